// ----- hw/rtl/serial_link_port_registers_macros.svh -----
// ----------------------------------------------------------------------------
// Serial link port assertion macros
// Check macros for the serial link port; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINK_PORT_REGISTERS_MACROS_SVH
`define SERIAL_LINK_PORT_REGISTERS_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SLPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serial link port check failed");
// next-cycle implication
`define SLPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serial link port check failed");
`else
`define SLPR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLPR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/slpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial link port package
// Operation codes, register addresses, masks and the word types shared by
// the stages of the serial link port.
// ----------------------------------------------------------------------------
package slpr_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_READ   = 2'd0;
    localparam t_op OP_WRITE  = 2'd1;
    localparam t_op OP_ARRIVE = 2'd2;

    localparam logic [15:0] ADDR_DATA    = 16'hFF01;
    localparam logic [15:0] ADDR_CONTROL = 16'hFF02;

    localparam logic [7:0] CTRL_READ_ONES  = 8'h7C;
    localparam logic [7:0] CTRL_WRITE_MASK = 8'h83;
    localparam logic [7:0] CTRL_START      = 8'h80;
    localparam logic [7:0] OPEN_BUS        = 8'hFF;

    typedef struct packed {
        t_op         op;
        logic [15:0] address;
        logic [7:0]  write_value;
        logic [7:0]  link_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       send_valid;
        logic [7:0] send_data;
        logic [7:0] send_control;
        logic       interrupt_request;
        logic       unknown_access;
    } t_result;

endpackage

// ----- hw/rtl/serial_link_port_registers.sv -----
// ----------------------------------------------------------------------------
// Serial link port registers
// Data register at 0xFF01 and control register at 0xFF02 of a byte-wide
// serial link, driven by bus reads, bus writes and bytes from the partner.
// ----------------------------------------------------------------------------
// One word is taken every cycle when the output side keeps up. Each word
// passes an input register, then the register file decodes it and updates
// the port registers as it moves into the result register, from which its
// result is offered. The input register and the result register each hold
// one word, so input stays open while a finished result waits to be taken
// and the input register is empty; o_ready follows i_ready when both are full.
`include "serial_link_port_registers_macros.svh"

module serial_link_port_registers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_value,
    input  logic [7:0]  i_link_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_send_valid,
    output logic [7:0]  o_send_data,
    output logic [7:0]  o_send_control,
    output logic        o_interrupt_request,
    output logic        o_unknown_access
);
    import slpr_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_vld;
    logic    out_free;
    logic    advance;
    t_result next_result;
    t_result out_result;

    assign in_item.op          = i_op;
    assign in_item.address     = i_address;
    assign in_item.write_value = i_write_value;
    assign in_item.link_byte   = i_link_byte;

    // move a word on when the result register can take it
    assign advance = held_vld && out_free;

    slpr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_vld),
        .o_item    (held_item)
    );

    slpr_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (held_item),
        .o_result  (next_result)
    );

    slpr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (next_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_read_data         = out_result.read_data;
    assign o_send_valid        = out_result.send_valid;
    assign o_send_data         = out_result.send_data;
    assign o_send_control      = out_result.send_control;
    assign o_interrupt_request = out_result.interrupt_request;
    assign o_unknown_access    = out_result.unknown_access;

    `SLPR_ASSERT_IMP(a_send_has_start, i_clk, i_rst_n, o_valid && o_send_valid, o_send_control[7])
    `SLPR_ASSERT_IMP(a_send_xor_irq, i_clk, i_rst_n, o_valid, !(o_send_valid && o_interrupt_request))
    `SLPR_ASSERT_IMP(a_unknown_quiet, i_clk, i_rst_n, o_valid && o_unknown_access, !o_send_valid && !o_interrupt_request)
    `SLPR_ASSERT_NXT(a_advance_loads, i_clk, i_rst_n, advance, o_valid)

endmodule

// ----- hw/rtl/slpr_in_reg.sv -----
// ----------------------------------------------------------------------------
// Serial link port input register
// Holds one incoming word until the register file takes it.
// ----------------------------------------------------------------------------
module slpr_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  slpr_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output slpr_pkg::t_item o_item
);
    import slpr_pkg::*;

    logic  r_vld;
    t_item r_item;

    // free when empty or draining this cycle
    assign o_ready = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

// ----- hw/rtl/slpr_regfile.sv -----
// ----------------------------------------------------------------------------
// Serial link port register file
// Data, control and arrival registers with the bus decode and transfer
// control; yields the result of the word held in the input register.
// ----------------------------------------------------------------------------
module slpr_regfile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  slpr_pkg::t_item   i_item,
    output slpr_pkg::t_result o_result
);
    import slpr_pkg::*;

    logic [7:0] r_data_byte,    n_data_byte;
    logic [7:0] r_control_byte, n_control_byte;
    logic       r_active,       n_active;
    logic       r_pending,      n_pending;
    logic [7:0] r_arrived_byte, n_arrived_byte;
    logic [7:0] masked_value;
    t_result    res;

    assign masked_value = i_item.write_value & CTRL_WRITE_MASK;

    always_comb begin
        n_data_byte    = r_data_byte;
        n_control_byte = r_control_byte;
        n_active       = r_active;
        n_pending      = r_pending;
        n_arrived_byte = r_arrived_byte;
        res            = '0;
        case (i_item.op)
            OP_READ: begin
                if (i_item.address == ADDR_DATA) begin
                    // a fresh byte is returned once, then the stored data
                    if (r_pending) begin
                        n_pending     = 1'b0;
                        res.read_data = r_arrived_byte;
                    end else begin
                        res.read_data = r_data_byte;
                    end
                end else if (i_item.address == ADDR_CONTROL) begin
                    res.read_data = r_control_byte | CTRL_READ_ONES;
                end else begin
                    res.read_data      = OPEN_BUS;
                    res.unknown_access = 1'b1;
                end
            end
            OP_WRITE: begin
                if (i_item.address == ADDR_DATA) begin
                    n_data_byte = i_item.write_value;
                end else if (i_item.address == ADDR_CONTROL) begin
                    n_control_byte = masked_value;
                    // start only when idle; a busy write just updates control
                    if (((masked_value & CTRL_START) != 8'h00) && !r_active) begin
                        n_active         = 1'b1;
                        n_pending        = 1'b0;
                        res.send_valid   = 1'b1;
                        res.send_data    = r_data_byte;
                        res.send_control = masked_value;
                    end
                end else begin
                    res.unknown_access = 1'b1;
                end
            end
            OP_ARRIVE: begin
                // drop the byte unless a transfer is running
                if (r_active) begin
                    n_arrived_byte        = i_item.link_byte;
                    n_pending             = 1'b1;
                    n_active              = 1'b0;
                    n_control_byte        = r_control_byte & ~CTRL_START;
                    res.interrupt_request = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_byte    <= 8'h00;
            r_control_byte <= 8'h00;
            r_active       <= 1'b0;
            r_pending      <= 1'b0;
            r_arrived_byte <= 8'h00;
        end else if (i_advance) begin
            r_data_byte    <= n_data_byte;
            r_control_byte <= n_control_byte;
            r_active       <= n_active;
            r_pending      <= n_pending;
            r_arrived_byte <= n_arrived_byte;
        end
    end

    assign o_result = res;

endmodule

// ----- hw/rtl/slpr_out_reg.sv -----
// ----------------------------------------------------------------------------
// Serial link port result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module slpr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  slpr_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output slpr_pkg::t_result o_result
);
    import slpr_pkg::*;

    logic    r_vld;
    t_result r_result;

    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_result;

endmodule

// ----- tb/sv/serial_link_port_monitor.sv -----
// ----------------------------------------------------------------------------
// Serial link port monitor
// Watches the request and response channels of the serial link port, keeps
// its own copy of the port registers, predicts the response to every word
// taken and compares each response given, field by field, in order.
// ----------------------------------------------------------------------------
module serial_link_port_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_value,
    input  logic [7:0]  i_link_byte,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [7:0]  i_read_data,
    input  logic        i_send_valid,
    input  logic [7:0]  i_send_data,
    input  logic [7:0]  i_send_control,
    input  logic        i_interrupt_request,
    input  logic        i_unknown_access,
    output int          o_mismatches,
    output int          o_responses_due
);

    import slpr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the port registers
    logic [7:0] data_q;
    logic [7:0] control_q;
    logic       busy_q;
    logic       rx_pending_q;
    logic [7:0] rx_byte_q;

    t_result    responses_due[$];
    t_result    seen;
    t_result    wanted;
    int         mismatches;

    function automatic t_result port_access_response(input t_op op, input logic [15:0] addr,
                                                     input logic [7:0] wval,
                                                     input logic [7:0] lbyte);
        t_result r;
        r = '0;
        case (op)
            OP_READ: begin
                if (addr == ADDR_DATA) begin
                    // a fresh byte from the partner is returned once only
                    if (rx_pending_q) begin
                        rx_pending_q = 1'b0;
                        r.read_data  = rx_byte_q;
                    end else begin
                        r.read_data = data_q;
                    end
                end else if (addr == ADDR_CONTROL) begin
                    r.read_data = control_q | CTRL_READ_ONES;
                end else begin
                    r.read_data      = OPEN_BUS;
                    r.unknown_access = 1'b1;
                end
            end
            OP_WRITE: begin
                if (addr == ADDR_DATA) begin
                    data_q = wval;
                end else if (addr == ADDR_CONTROL) begin
                    control_q = wval & CTRL_WRITE_MASK;
                    if ((control_q & CTRL_START) != 8'h00 && !busy_q) begin
                        busy_q         = 1'b1;
                        rx_pending_q   = 1'b0;
                        r.send_valid   = 1'b1;
                        r.send_data    = data_q;
                        r.send_control = control_q;
                    end
                end else begin
                    r.unknown_access = 1'b1;
                end
            end
            OP_ARRIVE: begin
                // drop the byte unless a transfer is running
                if (busy_q) begin
                    rx_byte_q           = lbyte;
                    rx_pending_q        = 1'b1;
                    busy_q              = 1'b0;
                    control_q           = control_q & ~CTRL_START;
                    r.interrupt_request = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            data_q       = '0;
            control_q    = '0;
            busy_q       = 1'b0;
            rx_pending_q = 1'b0;
            rx_byte_q    = '0;
            responses_due.delete();
        end else begin
            // push before pop, so a response in the same cycle as its request would still line up
            if (i_req_valid && i_req_ready) begin
                responses_due.push_back(port_access_response(t_op'(i_op), i_address,
                                                             i_write_value, i_link_byte));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                seen.read_data         = i_read_data;
                seen.send_valid        = i_send_valid;
                seen.send_data         = i_send_data;
                seen.send_control      = i_send_control;
                seen.interrupt_request = i_interrupt_request;
                seen.unknown_access    = i_unknown_access;
                if (responses_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] response word with none outstanding: rd=%02h",
                                 $time, seen.read_data);
                    end
                end else begin
                    wanted = responses_due.pop_front();
                    if (seen !== wanted) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("[%0t] response mismatch (expected/actual): ", $time,
                                     "rd %02h/%02h sv %0b/%0b ",
                                     wanted.read_data, seen.read_data,
                                     wanted.send_valid, seen.send_valid,
                                     "sd %02h/%02h sc %02h/%02h ",
                                     wanted.send_data, seen.send_data,
                                     wanted.send_control, seen.send_control,
                                     "irq %0b/%0b unk %0b/%0b",
                                     wanted.interrupt_request, seen.interrupt_request,
                                     wanted.unknown_access, seen.unknown_access);
                        end
                    end
                end
            end
        end
        o_mismatches    <= mismatches;
        o_responses_due <= responses_due.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Serial link port testbench
// Drives bus reads, bus writes and partner bytes into the serial link port
// with random gaps on both channels: a directed opening, then mostly whole
// transfer sequences mixed with stray words. The monitor judges responses.
// ----------------------------------------------------------------------------
module tb_top;

    import slpr_pkg::*;

    localparam t_op OP_UNDEFINED  = 2'd3;
    localparam int  RANDOM_WORDS  = 1300;
    localparam int  SETTLE_CYCLES = 10;
    localparam int  RUN_LIMIT     = 8 * 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  op = OP_READ;
    logic [15:0] address = '0;
    logic [7:0]  write_value = '0;
    logic [7:0]  link_byte = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [7:0]  read_data;
    logic        send_valid;
    logic [7:0]  send_data;
    logic [7:0]  send_control;
    logic        interrupt_request;
    logic        unknown_access;

    int          mismatches;
    int          responses_due;
    int          words_sent = 0;
    int          no_idle_left = 0;

    always #4 clk = ~clk;

    serial_link_port_registers i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (req_valid),
        .o_ready             (req_ready),
        .i_op                (op),
        .i_address           (address),
        .i_write_value       (write_value),
        .i_link_byte         (link_byte),
        .o_valid             (rsp_valid),
        .i_ready             (rsp_ready),
        .o_read_data         (read_data),
        .o_send_valid        (send_valid),
        .o_send_data         (send_data),
        .o_send_control      (send_control),
        .o_interrupt_request (interrupt_request),
        .o_unknown_access    (unknown_access)
    );

    serial_link_port_monitor i_monitor (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_req_valid         (req_valid),
        .i_req_ready         (req_ready),
        .i_op                (op),
        .i_address           (address),
        .i_write_value       (write_value),
        .i_link_byte         (link_byte),
        .i_rsp_valid         (rsp_valid),
        .i_rsp_ready         (rsp_ready),
        .i_read_data         (read_data),
        .i_send_valid        (send_valid),
        .i_send_data         (send_data),
        .i_send_control      (send_control),
        .i_interrupt_request (interrupt_request),
        .i_unknown_access    (unknown_access),
        .o_mismatches        (mismatches),
        .o_responses_due     (responses_due)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return ADDR_DATA;
        if (r < 80) return ADDR_CONTROL;
        if (r < 84) return ADDR_DATA - 16'd1;
        if (r < 88) return ADDR_CONTROL + 16'd1;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // hold the word until taken, then idle the request side for a random gap, which may be zero
    task automatic send_word(input t_op w_op, input logic [15:0] w_addr,
                             input logic [7:0] w_val, input logic [7:0] w_link);
        int n;
        req_valid   <= 1'b1;
        op          <= w_op;
        address     <= w_addr;
        write_value <= w_val;
        link_byte   <= w_link;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        words_sent++;
        n = gap_length();
        if (no_idle_left > 0) begin
            no_idle_left--;
            n = 0;
        end
        if (n > 0) begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic await_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (responses_due != 0) @(posedge clk);
    endtask

    task automatic stray_word();
        int  r;
        t_op w_op;
        r = $urandom_range(0, 99);
        if (r < 35) w_op = OP_READ;
        else if (r < 70) w_op = OP_WRITE;
        else if (r < 90) w_op = OP_ARRIVE;
        else w_op = OP_UNDEFINED;
        send_word(w_op, pick_address(), rand_byte(), rand_byte());
    endtask

    // load data, start, poke while busy, take the partner byte, read back
    task automatic transfer_sequence();
        int extras;
        if ($urandom_range(0, 99) < 80) send_word(OP_WRITE, ADDR_DATA, rand_byte(), rand_byte());
        send_word(OP_WRITE, ADDR_CONTROL, rand_byte() | CTRL_START, rand_byte());
        extras = $urandom_range(0, 2);
        repeat (extras) begin
            send_word($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                      $urandom_range(0, 1) ? ADDR_DATA : ADDR_CONTROL,
                      rand_byte(), rand_byte());
        end
        if ($urandom_range(0, 99) < 90) send_word(OP_ARRIVE, pick_address(), rand_byte(),
                                                  rand_byte());
        if ($urandom_range(0, 99) < 85) send_word(OP_READ, ADDR_DATA, rand_byte(), rand_byte());
        if ($urandom_range(0, 99) < 40) send_word(OP_READ, ADDR_DATA, rand_byte(), rand_byte());
        if ($urandom_range(0, 99) < 30) send_word(OP_READ, ADDR_CONTROL, rand_byte(),
                                                  rand_byte());
    endtask

    // response side: bursts of ready, broken by gaps
    initial begin
        int n;
        @(posedge clk);
        forever begin
            rsp_ready <= 1'b1;
            n = ($urandom_range(0, 99) < 5) ? $urandom_range(60, 150) : $urandom_range(1, 8);
            repeat (n) @(posedge clk);
            n = gap_length();
            if (n > 0) begin
                rsp_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial begin
        int  first_random;
        bit  paused;
        paused = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset values and undecoded addresses
        send_word(OP_READ,  ADDR_DATA,    8'h00, 8'h00);
        send_word(OP_READ,  ADDR_CONTROL, 8'h00, 8'h00);
        send_word(OP_READ,  16'hFF00,     8'h00, 8'h00);
        send_word(OP_READ,  16'h0000,     8'hFF, 8'hFF);
        send_word(OP_WRITE, 16'hFFFF,     8'hFF, 8'h00);
        // partner byte while idle is dropped
        send_word(OP_ARRIVE, ADDR_DATA,   8'h00, 8'h99);
        send_word(OP_WRITE, ADDR_DATA,    8'hA5, 8'h00);
        send_word(OP_WRITE, ADDR_CONTROL, 8'hFF, 8'h00);
        send_word(OP_READ,  ADDR_CONTROL, 8'h00, 8'h00);
        // control writes while busy update the register but send nothing
        send_word(OP_WRITE, ADDR_CONTROL, 8'h80, 8'h00);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h00, 8'h00);
        send_word(OP_ARRIVE, 16'h0000,    8'hFF, 8'h3C);
        send_word(OP_READ,  ADDR_DATA,    8'h00, 8'h00);
        send_word(OP_READ,  ADDR_DATA,    8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h81, 8'h00);
        send_word(OP_ARRIVE, ADDR_CONTROL, 8'h80, 8'hFF);
        // a new start drops the unread partner byte
        send_word(OP_WRITE, ADDR_CONTROL, 8'h80, 8'h00);
        send_word(OP_READ,  ADDR_DATA,    8'h00, 8'h00);
        send_word(OP_ARRIVE, ADDR_DATA,   8'h55, 8'h00);
        send_word(OP_UNDEFINED, ADDR_CONTROL, 8'hFF, 8'hFF);
        send_word(OP_WRITE, ADDR_DATA,    8'h5A, 8'h00);
        send_word(OP_READ,  ADDR_DATA,    8'h00, 8'h00);
        send_word(OP_READ,  ADDR_DATA,    8'h00, 8'h00);
        send_word(OP_WRITE, ADDR_CONTROL, 8'h7C, 8'h00);
        send_word(OP_READ,  16'hFFFF,     8'h00, 8'h00);

        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 5) no_idle_left = $urandom_range(30, 80);
            if ($urandom_range(0, 99) < 70) transfer_sequence();
            else stray_word();
            if (!paused && words_sent - first_random >= RANDOM_WORDS / 2) begin
                await_drain();
                paused = 1'b1;
            end
        end

        await_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && responses_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/slpr_pkg.sv
hw/rtl/slpr_in_reg.sv
hw/rtl/slpr_regfile.sv
hw/rtl/slpr_out_reg.sv
hw/rtl/serial_link_port_registers.sv
tb/sv/serial_link_port_monitor.sv
tb/sv/tb_top.sv
